@@ rtl/core/lups_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lups_pkg
// Shared constants and types of the pivoting LU linear solver.
// -----------------------------------------------------------------------------
package lups_pkg;

	localparam int N     = 8;
	localparam int LG_N  = 3;
	localparam int IDX_W = LG_N + 1;
	localparam int AW    = 2 * LG_N;
	localparam int DEPTH = N * N;
	localparam int CNT_W = AW + 1;
	localparam int QW    = 32;
	localparam int ACC_W = 52;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY,
		ST_DOT_BASE,
		ST_DOT_BASEW,
		ST_DOT_RD,
		ST_DOT_MUL,
		ST_DOT_ACC,
		ST_DOT_FIN,
		ST_PIVOT,
		ST_DIV_LD,
		ST_DIV_WAIT,
		ST_BDIAG,
		ST_BDIAGW,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_S,
		PH_U,
		PH_L,
		PH_F,
		PH_B
	} phase_t;

endpackage
`default_nettype wire

@@ rtl/core/lups_div.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lups_div
// Radix-2 restoring divider for Q16.16 quotients, rounded and saturated.
// -----------------------------------------------------------------------------
module lups_div
	import lups_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [QW-1:0] num,
	input  wire logic signed [QW-1:0] den,
	output logic                      done,
	output logic signed [QW-1:0]      quo
);

	localparam int DW = QW + 16;

	logic          busy_q;
	logic [5:0]    cnt_q;
	logic [DW-1:0] dvd_q;
	logic [QW-1:0] rem_q;
	logic [QW-1:0] dm_q;
	logic          neg_q;
	logic          zero_q;
	logic          done_q;

	logic [QW-1:0] nmag;
	logic [QW-1:0] dmag;
	logic [QW:0]   rem2;
	logic          qbit;
	logic [DW-1:0] qclip;
	logic [QW-1:0] qs;

	// Form magnitudes and the trial remainder
	always_comb begin
		nmag  = num[QW-1] ? (~num + 1'b1) : num;
		dmag  = den[QW-1] ? (~den + 1'b1) : den;
		rem2  = {rem_q, dvd_q[DW-1]};
		qbit  = (rem2 >= {1'b0, dm_q});
		qclip = (dvd_q > DW'(33'h080000000)) ? DW'(33'h080000000) : dvd_q;
		qs    = qclip[QW-1:0];
	end

	// Step one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= ({nmag, 16'h0000}) + DW'(dmag >> 1);
			dm_q   <= dmag;
			rem_q  <= '0;
			neg_q  <= num[QW-1] ^ den[QW-1];
			zero_q <= (dmag == '0);
		end else if (busy_q) begin
			rem_q <= QW'(qbit ? (rem2 - {1'b0, dm_q}) : rem2);
			dvd_q <= {dvd_q[DW-2:0], qbit};
		end
	end

	// Apply sign and saturate
	always_comb begin
		done = done_q;
		if (zero_q)
			quo = '0;
		else if (neg_q)
			quo = ~qs + 1'b1;
		else if (qclip[QW-1])
			quo = {1'b0, {(QW-1){1'b1}}};
		else
			quo = qs;
	end

endmodule
`default_nettype wire

@@ rtl/core/lu_pivot_linear_solver_core.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// lu_pivot_linear_solver_core
// Q16.16 linear solver: LU with partial pivoting and two substitutions.
// -----------------------------------------------------------------------------
// Usage: stream matrix elements on the input channel (row_index, col_index,
// element_value); col_index 8 writes the right-hand side of the row. An
// element is accepted whenever in_valid is high while the block is idle. The
// word with final_element = 1 is stored if its column is 8 or less and then
// starts a solve; in_ready stays low until all eight solution words are taken.
// A solve first copies the loaded matrix into a work memory, then runs every
// dot product on one shared multiplier, stepping each term through the read,
// multiply and accumulate states, and every quotient on one radix-2 divider
// in 48 quotient steps plus load and hand-off.
// Results come out in index order, last_result on index 7; the block holds
// each word while out_ready is low. A zero pivot ends the solve early with
// singular set and all values zero. Reset clears control state and the
// singular flag; loaded elements are undefined until written.
// -----------------------------------------------------------------------------
module lu_pivot_linear_solver_core
	import lups_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [2:0]           row_index,
	input  wire logic [3:0]           col_index,
	input  wire logic signed [31:0]   element_value,
	input  wire logic                 final_element,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [2:0]                solution_index,
	output logic signed [31:0]        solution_value,
	output logic                      singular,
	output logic                      last_result
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(N - 1);

	state_t state_q, state_d;
	phase_t phase_q;

	logic [QW-1:0]       store_mem [DEPTH];
	logic [QW-1:0]       work_mem  [DEPTH];
	logic [QW-1:0]       store_rd_q;
	logic [QW-1:0]       rda_q, rdb_q;
	logic [QW-1:0]       rhs_q [N];
	logic [QW-1:0]       s_q   [N];
	logic [QW-1:0]       y_q   [N];
	logic [QW-1:0]       x_q   [N];
	logic [LG_N-1:0]     perm_q [N];

	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    k_q, i_q, m_q, best_q;
	logic [QW-1:0]       bestmag_q, bestval_q, piv_q, num_q, base_q;
	logic signed [63:0]  prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                singular_q;

	logic                in_acc, out_acc;
	logic [LG_N-1:0]     pi, pk, pm, pb;
	logic [AW-1:0]       addr_a, addr_b, waddr;
	logic [QW-1:0]       wdata;
	logic                we;
	logic [IDX_W-1:0]    m_end, m_start;
	logic [LG_N-1:0]     yaddr;
	logic signed [QW-1:0] op_b;
	logic [63:0]         pmag;
	logic [47:0]         rmag;
	logic signed [ACC_W-1:0] rnd, diff;
	logic [QW-1:0]       res, res_mag;
	logic                div_start, div_done;
	logic signed [QW-1:0] div_num, div_den, div_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Resolve physical rows through the permutation
	always_comb begin
		pi = perm_q[i_q[LG_N-1:0]];
		pk = perm_q[k_q[LG_N-1:0]];
		pm = perm_q[m_q[LG_N-1:0]];
		pb = perm_q[best_q[LG_N-1:0]];
		yaddr = (state_q == ST_DOT_BASEW) ? i_q[LG_N-1:0] : m_q[LG_N-1:0];
		m_start = (phase_q == PH_B) ? i_q + 1'b1 : '0;
		unique case (phase_q)
			PH_S, PH_U: m_end = k_q;
			PH_F:       m_end = i_q;
			default:    m_end = IDX_W'(N);
		endcase
	end

	// Select work memory read addresses
	always_comb begin
		addr_a = {pi, m_q[LG_N-1:0]};
		addr_b = {pm, k_q[LG_N-1:0]};
		unique case (state_q)
			ST_DOT_BASE: begin
				if (phase_q == PH_U)
					addr_a = {pk, i_q[LG_N-1:0]};
				else
					addr_a = {pi, k_q[LG_N-1:0]};
			end
			ST_BDIAG: addr_a = {pi, i_q[LG_N-1:0]};
			default: begin
				if (phase_q == PH_U) begin
					addr_a = {pk, m_q[LG_N-1:0]};
					addr_b = {pm, i_q[LG_N-1:0]};
				end
			end
		endcase
	end

	// Round product and form the saturated difference
	always_comb begin
		op_b = (phase_q == PH_F) ? y_q[yaddr] :
			(phase_q == PH_B) ? x_q[m_q[LG_N-1:0]] : rdb_q;
		pmag = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
		rmag = 48'((pmag + 64'd32768) >> 16);
		rnd  = prod_q[63] ? -ACC_W'({1'b0, rmag}) : ACC_W'({1'b0, rmag});
		diff = ACC_W'(signed'(base_q)) - acc_q;
		if (diff > ACC_W'(32'sh7fffffff))
			res = 32'h7fffffff;
		else if (diff < -ACC_W'(33'sh080000000))
			res = 32'h80000000;
		else
			res = diff[QW-1:0];
		res_mag = res[QW-1] ? (~res + 1'b1) : res;
	end

	// Drive the work memory write port and the divider
	always_comb begin
		we    = 1'b0;
		waddr = {pk, i_q[LG_N-1:0]};
		wdata = res;
		div_start = 1'b0;
		div_num = (phase_q == PH_L) ? s_q[pi] : num_q;
		div_den = (phase_q == PH_L) ? piv_q : rda_q;
		unique case (state_q)
			ST_COPY: begin
				we    = (cnt_q != '0);
				waddr = AW'(cnt_q - 1'b1);
				wdata = store_rd_q;
			end
			ST_PIVOT: begin
				we    = (bestmag_q != '0);
				waddr = {pb, k_q[LG_N-1:0]};
				wdata = bestval_q;
			end
			ST_DOT_FIN: we = (phase_q == PH_U);
			ST_DIV_LD, ST_BDIAGW: div_start = 1'b1;
			ST_DIV_WAIT: begin
				we    = div_done && (phase_q == PH_L);
				waddr = {pi, k_q[LG_N-1:0]};
				wdata = div_q;
			end
			default: ;
		endcase
	end

	// Load and work memories
	always_ff @(posedge clk) begin
		if (in_acc && (32'(row_index) < N) && (32'(col_index) < N))
			store_mem[{row_index[LG_N-1:0], col_index[LG_N-1:0]}] <= element_value;
		if (in_acc && (32'(row_index) < N) && (32'(col_index) == N))
			rhs_q[row_index[LG_N-1:0]] <= element_value;
		store_rd_q <= store_mem[cnt_q[AW-1:0]];
		if (we)
			work_mem[waddr] <= wdata;
		rda_q <= work_mem[addr_a];
		rdb_q <= work_mem[addr_b];
	end

	lups_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_q)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_acc && final_element) state_d = ST_COPY;
			ST_COPY:      if (cnt_q == CNT_W'(DEPTH)) state_d = ST_DOT_BASE;
			ST_DOT_BASE:  state_d = ST_DOT_BASEW;
			ST_DOT_BASEW: state_d = (m_start >= m_end) ? ST_DOT_FIN : ST_DOT_RD;
			ST_DOT_RD:    state_d = ST_DOT_MUL;
			ST_DOT_MUL:   state_d = ST_DOT_ACC;
			ST_DOT_ACC:   state_d = (m_q + 1'b1 >= m_end) ? ST_DOT_FIN : ST_DOT_RD;
			ST_DOT_FIN: begin
				unique case (phase_q)
					PH_S:    state_d = (i_q == LAST) ? ST_PIVOT : ST_DOT_BASE;
					PH_U:    state_d = (i_q == LAST) ? ST_DIV_LD : ST_DOT_BASE;
					PH_B:    state_d = ST_BDIAG;
					default: state_d = ST_DOT_BASE;
				endcase
			end
			ST_PIVOT:     state_d = (bestmag_q == '0) ? ST_OUT : ST_DOT_BASE;
			ST_DIV_LD:    state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					if (phase_q == PH_L)
						state_d = (i_q == LAST) ? ST_DOT_BASE : ST_DIV_LD;
					else
						state_d = (i_q == '0) ? ST_OUT : ST_DOT_BASE;
				end
			end
			ST_BDIAG:     state_d = ST_BDIAGW;
			ST_BDIAGW:    state_d = ST_DIV_WAIT;
			ST_OUT:       if (out_acc && m_q == LAST) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_S;
			singular_q <= 1'b0;
			cnt_q      <= '0;
			k_q        <= '0;
			i_q        <= '0;
			m_q        <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc && final_element)
						singular_q <= 1'b0;
				end
				ST_COPY: begin
					cnt_q   <= cnt_q + 1'b1;
					k_q     <= '0;
					i_q     <= '0;
					phase_q <= PH_S;
				end
				ST_DOT_BASEW: m_q <= m_start;
				ST_DOT_ACC:   m_q <= m_q + 1'b1;
				ST_DOT_FIN: begin
					unique case (phase_q)
						PH_S, PH_F: begin
							if (i_q != LAST)
								i_q <= i_q + 1'b1;
							else if (phase_q == PH_F)
								phase_q <= PH_B;
						end
						PH_U: begin
							if (i_q != LAST) begin
								i_q <= i_q + 1'b1;
							end else begin
								phase_q <= PH_L;
								i_q     <= k_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
				ST_PIVOT: begin
					if (bestmag_q == '0) begin
						singular_q <= 1'b1;
						m_q        <= '0;
					end else if (k_q == LAST) begin
						phase_q <= PH_F;
						i_q     <= '0;
					end else begin
						phase_q <= PH_U;
						i_q     <= k_q + 1'b1;
					end
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (phase_q == PH_L) begin
							if (i_q != LAST) begin
								i_q <= i_q + 1'b1;
							end else begin
								phase_q <= PH_S;
								k_q     <= k_q + 1'b1;
								i_q     <= k_q + 1'b1;
							end
						end else if (i_q == '0) begin
							m_q <= '0;
						end else begin
							i_q <= i_q - 1'b1;
						end
					end
				end
				ST_OUT: if (out_acc) m_q <= m_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_COPY && cnt_q == '0) begin
			for (int j = 0; j < N; j++)
				perm_q[j] <= LG_N'(j);
		end
		if (state_q == ST_DOT_BASEW) begin
			if (phase_q == PH_F)
				base_q <= rhs_q[pi];
			else if (phase_q == PH_B)
				base_q <= y_q[yaddr];
			else
				base_q <= rda_q;
			acc_q <= '0;
		end
		if (state_q == ST_DOT_MUL)
			prod_q <= signed'(rda_q) * op_b;
		if (state_q == ST_DOT_ACC)
			acc_q <= acc_q + rnd;
		if (state_q == ST_DOT_FIN) begin
			unique case (phase_q)
				PH_S: begin
					s_q[pi] <= res;
					if (i_q == k_q || res_mag > bestmag_q) begin
						best_q    <= i_q;
						bestmag_q <= res_mag;
						bestval_q <= res;
					end
				end
				PH_F:    y_q[i_q[LG_N-1:0]] <= res;
				PH_B:    num_q <= res;
				default: ;
			endcase
		end
		if (state_q == ST_PIVOT && bestmag_q != '0) begin
			// Swap rows only when the pivot row moves
			if (best_q != k_q) begin
				perm_q[k_q[LG_N-1:0]]    <= pb;
				perm_q[best_q[LG_N-1:0]] <= pk;
			end
			piv_q <= bestval_q;
		end
		if (state_q == ST_DIV_WAIT && div_done && phase_q == PH_B)
			x_q[i_q[LG_N-1:0]] <= div_q;
	end

	// Result word
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		out_valid      = (state_q == ST_OUT);
		solution_index = m_q[LG_N-1:0];
		solution_value = singular_q ? '0 : x_q[m_q[LG_N-1:0]];
		singular       = singular_q;
		last_result    = (m_q == LAST);
	end

endmodule
`default_nettype wire

@@ sim/lu_pivot_linear_solver_core_tb.sv @@
// -----------------------------------------------------------------------------
// lu_pivot_linear_solver_core_tb
// Streams augmented systems into the solver and compares every solution word
// against a predictor that does the same Q16.16 pivoting LU solve. The driver
// and the receiver stall at random.
// -----------------------------------------------------------------------------
module lu_pivot_linear_solver_core_tb;
	import lups_pkg::*;

	localparam int COL_RHS  = N;
	localparam int IDLE_CAP = 40000;
	localparam int ITEMS    = 150;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;

	typedef struct {
		logic [2:0]  row;
		logic [3:0]  col;
		logic [31:0] value;
		logic        fin;
	} element_t;

	typedef struct {
		logic [2:0]  idx;
		logic [31:0] value;
		logic        sing;
		logic        last;
	} solution_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         row_index = '0;
	logic [3:0]         col_index = '0;
	logic signed [31:0] element_value = '0;
	logic               final_element = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         solution_index;
	logic signed [31:0] solution_value;
	logic               singular;
	logic               last_result;

	element_t  pending_words[$];
	solution_t solutions_due[$];
	longint    coef[N][N];
	longint    rhs[N];
	int        errors = 0;
	int        idle_cycles = 0;
	int        in_gap = 0, in_burst = 0;
	int        out_gap = 0, out_burst = 0;

	lu_pivot_linear_solver_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.row_index(row_index), .col_index(col_index),
		.element_value(element_value), .final_element(final_element),
		.out_valid(out_valid), .out_ready(out_ready),
		.solution_index(solution_index), .solution_value(solution_value),
		.singular(singular), .last_result(last_result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---- fixed-point helpers ----
	function automatic longint sat32(longint v);
		if (v > QMAX) return QMAX;
		if (v < QMIN) return QMIN;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint p, m;
		p = a * b;
		m = ((p < 0 ? -p : p) + 32768) >>> 16;
		return p < 0 ? -m : m;
	endfunction

	function automatic longint qdiv(longint n, longint d);
		longint nm, dm, q;
		nm = (n < 0 ? -n : n) * 65536;
		dm = d < 0 ? -d : d;
		if (dm == 0) return 0;
		q = (nm + dm / 2) / dm;
		if (q > 64'sh80000000) q = 64'sh80000000;
		return sat32(((n < 0) != (d < 0)) ? -q : q);
	endfunction

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	// ---- predictor: pivoting LU solve on a copy of the loaded system ----
	function automatic void solve_system();
		longint a[N][N];
		longint b[N], s[N], y[N], x[N];
		longint acc, t;
		int best;
		bit sing;
		solution_t r;
		a = coef;
		b = rhs;
		sing = 1'b0;
		for (int k = 0; k < N && !sing; k++) begin
			best = k;
			for (int i = k; i < N; i++) begin
				acc = 0;
				for (int m = 0; m < k; m++) acc += qmul(a[i][m], a[m][k]);
				s[i] = sat32(a[i][k] - acc);
				if (absval(s[i]) > absval(s[best])) best = i;
			end
			if (s[best] == 0) begin
				sing = 1'b1;
			end else begin
				if (best != k) begin
					for (int j = 0; j < N; j++) begin
						t = a[best][j]; a[best][j] = a[k][j]; a[k][j] = t;
					end
					t = s[best]; s[best] = s[k]; s[k] = t;
					t = b[best]; b[best] = b[k]; b[k] = t;
				end
				a[k][k] = s[k];
				for (int j = k + 1; j < N; j++) begin
					acc = 0;
					for (int m = 0; m < k; m++) acc += qmul(a[k][m], a[m][j]);
					a[k][j] = sat32(a[k][j] - acc);
				end
				for (int i = k + 1; i < N; i++) a[i][k] = qdiv(s[i], a[k][k]);
			end
		end
		for (int i = 0; i < N; i++) x[i] = 0;
		if (!sing) begin
			for (int i = 0; i < N; i++) begin
				acc = 0;
				for (int j = 0; j < i; j++) acc += qmul(a[i][j], y[j]);
				y[i] = sat32(b[i] - acc);
			end
			for (int i = N - 1; i >= 0; i--) begin
				acc = 0;
				for (int j = i + 1; j < N; j++) acc += qmul(a[i][j], x[j]);
				x[i] = qdiv(sat32(y[i] - acc), a[i][i]);
			end
		end
		for (int i = 0; i < N; i++) begin
			r.idx = i[2:0];
			r.value = x[i][31:0];
			r.sing = sing;
			r.last = (i == N - 1);
			solutions_due.push_back(r);
		end
	endfunction

	function automatic void take_word(element_t w);
		if (w.col < N) coef[w.row][w.col] = longint'($signed(w.value));
		else if (w.col == COL_RHS) rhs[w.row] = longint'($signed(w.value));
		if (w.fin) solve_system();
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		errors++;
	endtask

	// ---- stimulus helpers ----
	function automatic void add_word(int row, int col, logic [31:0] value, bit fin);
		element_t w;
		w.row = row[2:0];
		w.col = col[3:0];
		w.value = value;
		w.fin = fin;
		pending_words.push_back(w);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 6))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return 32'h0;
			4: return $urandom_range(0, 2) - 1;
			default: return $urandom_range(0, 32'h80000) - 32'h40000;
		endcase
	endfunction

	// load a full, mostly diagonally dominant system; returns words added
	function automatic int load_system(bit fin);
		logic [31:0] v;
		for (int r = 0; r < N; r++) begin
			for (int c = 0; c <= N; c++) begin
				if (c == r) begin
					v = 32'h00100000 + $urandom_range(0, 32'h00400000);
					if ($urandom_range(0, 1)) v = -v;
				end else if (c == COL_RHS) begin
					v = pick_value();
				end else if ($urandom_range(0, 9) == 0) begin
					v = pick_value();
				end else begin
					v = $urandom_range(0, 32'h40000) - 32'h20000;
				end
				add_word(r, c, v, fin && r == N - 1 && c == N);
			end
		end
		return N * (N + 1);
	endfunction

	// ---- input driver ----
	always @(posedge clk or negedge arst_n) begin
		element_t w;
		bit fire;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			fire = in_valid && in_ready;
			if (fire) begin
				w.row = row_index;
				w.col = col_index;
				w.value = element_value;
				w.fin = final_element;
				take_word(w);
				if (in_burst > 0) begin
					in_burst--;
					in_gap = 0;
				end else if ($urandom_range(0, 5) == 0) begin
					in_burst = $urandom_range(5, 20);
					in_gap = 0;
				end else begin
					in_gap = $urandom_range(0, 14);
				end
			end
			if (!in_valid || fire) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					w = pending_words.pop_front();
					row_index <= w.row;
					col_index <= w.col;
					element_value <= w.value;
					final_element <= w.fin;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---- output monitor ----
	always @(posedge clk or negedge arst_n) begin
		solution_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (solutions_due.size() == 0) begin
					report_mismatch("unexpected word, index", 32'(solution_index), 32'h0);
				end else begin
					e = solutions_due.pop_front();
					if (solution_index !== e.idx)
						report_mismatch("solution_index", 32'(solution_index), 32'(e.idx));
					if (solution_value !== e.value)
						report_mismatch("solution_value", solution_value, e.value);
					if (singular !== e.sing)
						report_mismatch("singular", 32'(singular), 32'(e.sing));
					if (last_result !== e.last)
						report_mismatch("last_result", 32'(last_result), 32'(e.last));
				end
				if (out_burst > 0) begin
					out_burst--;
					out_gap = 0;
				end else if ($urandom_range(0, 4) == 0) begin
					out_burst = $urandom_range(8, 24);
					out_gap = 0;
				end else begin
					out_gap = $urandom_range(0, 14);
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---- watchdog on cycles with no handshake ----
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_CAP) begin
			$display("lu_pivot_linear_solver_core test failed");
			$finish;
		end
	end

	// ---- sequence ----
	initial begin
		int row;
		for (int r = 0; r < N; r++) begin
			rhs[r] = 0;
			for (int c = 0; c < N; c++) coef[r][c] = 0;
		end

		// first full system, solved on its last word
		void'(load_system(1'b1));

		// ignored columns, the last one still starts a solve
		add_word(2, 9, 32'h7fffffff, 1'b0);
		add_word(5, 15, 32'h80000000, 1'b1);
		// field extremes
		add_word(0, 0, 32'h80000000, 1'b0);
		add_word(7, COL_RHS, 32'h7fffffff, 1'b0);
		add_word(3, 3, 32'h0, 1'b1);
		// zero first column: zero pivot at the first step
		for (int r = 0; r < N; r++) add_word(r, 0, 32'h0, r == N - 1);
		// equal magnitudes in the first column: lowest row wins the pivot
		for (int r = 0; r < N; r++)
			add_word(r, 0, (r == 2) ? -32'sh10000 : 32'sh10000, r == N - 1);

		// random part: mostly small edits followed by a solve
		while (pending_words.size() < ITEMS) begin
			if ($urandom_range(0, 7) == 0 &&
				pending_words.size() + N * (N + 1) <= ITEMS + 10) begin
				void'(load_system(1'b1));
			end else begin
				row = $urandom_range(1, 10);
				for (int i = 0; i < row; i++) begin
					add_word($urandom_range(0, 7), $urandom_range(0, 15), pick_value(),
						i == row - 1);
				end
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_words.size() != 0 || in_valid || solutions_due.size() != 0);
		repeat (200) @(posedge clk);

		if (errors == 0) begin
			$display("lu_pivot_linear_solver_core test passed");
		end else begin
			$display("lu_pivot_linear_solver_core test failed");
		end
		$finish;
	end

endmodule

@@ lu_pivot_linear_solver_core.f @@
rtl/core/lups_pkg.sv
rtl/core/lups_div.sv
rtl/core/lu_pivot_linear_solver_core.sv
sim/lu_pivot_linear_solver_core_tb.sv
